### sv/punf_pkg.sv
// Shared types, constants and the Paeth predictor for the PNG scanline unfilter.
// No dependencies; the interfaces, the unfilter and the testbench import this package.
`timescale 1ns / 1ps

package punf_pkg;

    // Size defaults for the top level parameters
    localparam int MAX_ROW_BYTES_DEF   = 8192;
    localparam int MAX_PIXEL_BYTES_DEF = 8;

    // Configuration port geometry and register map
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 14;
    localparam int ROW_BYTES_W = 14;
    localparam int BPP_W       = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_BYTES       = 4'd0,
        REG_BYTES_PER_PIXEL = 4'd1
    } cfg_reg_t;

    // Filter types; anything above FILT_PAETH is an error
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    localparam logic [7:0] FILT_LAST_CODE = 8'd4;

    // Paeth predictor: pick the neighbor closest to left + above - corner
    function automatic logic [7:0] paeth_pick(
        input logic [7:0] left,
        input logic [7:0] above,
        input logic [7:0] corner
    );
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        da = $signed({2'b00, above}) - $signed({2'b00, corner});
        db = $signed({2'b00, left}) - $signed({2'b00, corner});
        dc = da + db;
        pa = da[9] ? 10'(-da) : 10'(da);
        pb = db[9] ? 10'(-db) : 10'(db);
        pc = dc[9] ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc)
        begin
            paeth_pick = left;
        end
        else if (pb <= pc)
        begin
            paeth_pick = above;
        end
        else
        begin
            paeth_pick = corner;
        end
    endfunction

endpackage

### sv/punf_intf.sv
// Valid/ready channel interfaces of the PNG scanline unfilter:
// filtered byte input, reconstructed byte output and configuration writes.
// Depends on punf_pkg for the configuration port widths.
`timescale 1ns / 1ps

interface punf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       image_end;

    modport source (output valid, output stream_byte, output image_end, input ready);
    modport sink   (input valid, input stream_byte, input image_end, output ready);
endinterface

interface punf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       error;

    modport source (output valid, output pixel_byte, output row_end, output error, input ready);
    modport sink   (input valid, input pixel_byte, input row_end, input error, output ready);
endinterface

interface punf_cfg_if
    import punf_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/punf_line_store.sv
// Previous-row line store: one write port, one registered read port,
// with write-to-read forwarding when both hit the same column in one cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module punf_line_store #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write the reconstructed byte
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read, forwarding a same-cycle write to the same column
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/png_scanline_unfilter.sv
// PNG scanline unfilter: takes one inflated byte per cycle and returns the
// reconstructed data byte two register stages later, at a sustained rate of one
// byte per cycle while the output is not stalled. The filter byte of each row
// gives no result; a filter type above 4 gives one result with error set and
// the block drops every byte up to and including the one marked image_end. Row
// control is updated when a byte is accepted and the line store is read then;
// the filter arithmetic runs in the following stage, which writes the line
// store and feeds the output register. The user writes row length and pixel
// size only while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps

module png_scanline_unfilter
    import punf_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    punf_in_if.sink     pixels_in,
    punf_out_if.source  pixels_out,
    punf_cfg_if.sink    cfg
);

    localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int LW = CW + 1;
    localparam int XW = (LW > ROW_BYTES_W) ? LW : ROW_BYTES_W;
    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int DW = (PW + 1 > BPP_W) ? PW + 1 : BPP_W;

    // Configuration registers
    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    logic [BPP_W-1:0]       bpp_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= ROW_BYTES_W'(1);
            bpp_reg       <= BPP_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ROW_BYTES:       row_bytes_reg <= cfg.data[ROW_BYTES_W-1:0];
                REG_BYTES_PER_PIXEL: bpp_reg       <= cfg.data[BPP_W-1:0];
                default:             ;
            endcase
        end
    end

    // Clamp the row length and the filter distance to their legal ranges
    logic [LW-1:0] eff_len;
    logic [PW-1:0] dist_idx;

    always_comb
    begin
        if (row_bytes_reg == '0)
        begin
            eff_len = LW'(1);
        end
        else if (XW'(row_bytes_reg) > XW'(MAX_ROW_BYTES))
        begin
            eff_len = LW'(MAX_ROW_BYTES);
        end
        else
        begin
            eff_len = LW'(row_bytes_reg);
        end
    end

    always_comb
    begin
        if (bpp_reg == '0)
        begin
            dist_idx = '0;
        end
        else if (DW'(bpp_reg) > DW'(MAX_PIXEL_BYTES))
        begin
            dist_idx = PW'(MAX_PIXEL_BYTES - 1);
        end
        else
        begin
            dist_idx = PW'(bpp_reg - BPP_W'(1));
        end
    end

    // Row control state
    logic          expect_filter_reg;
    logic          first_row_reg;
    logic          discard_reg;
    filter_t       filter_reg;
    logic [CW-1:0] col_reg;

    // Stage one: one data byte or one error request
    logic          s1_valid_reg;
    logic          s1_err_reg;
    logic [7:0]    s1_byte_reg;
    filter_t       s1_filter_reg;
    logic          s1_row_start_reg;
    logic          s1_above_zero_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_last_reg;

    // Output register
    logic       out_valid_reg;
    logic [7:0] out_pixel_reg;
    logic       out_row_end_reg;
    logic       out_error_reg;

    logic s1_go;
    logic in_fire;
    logic is_filter;
    logic is_data;
    logic bad_filter;
    logic s1_load;
    logic last_col;

    assign s1_go            = s1_valid_reg && (!out_valid_reg || pixels_out.ready);
    assign pixels_in.ready  = !s1_valid_reg || s1_go;
    assign in_fire          = pixels_in.valid && pixels_in.ready;
    assign is_filter        = !discard_reg && expect_filter_reg;
    assign is_data          = !discard_reg && !expect_filter_reg;
    assign bad_filter       = pixels_in.stream_byte > FILT_LAST_CODE;
    assign s1_load          = in_fire && (is_data || (is_filter && bad_filter));
    assign last_col         = (LW'(col_reg) + LW'(1)) >= eff_len;

    // Advance row control on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_filter_reg <= 1'b1;
            first_row_reg     <= 1'b1;
            discard_reg       <= 1'b0;
            filter_reg        <= FILT_NONE;
            col_reg           <= '0;
        end
        else if (in_fire)
        begin
            if (is_filter)
            begin
                if (bad_filter)
                begin
                    discard_reg <= 1'b1;
                end
                else
                begin
                    filter_reg        <= filter_t'(pixels_in.stream_byte[2:0]);
                    expect_filter_reg <= 1'b0;
                    col_reg           <= '0;
                end
            end
            else if (is_data)
            begin
                if (last_col)
                begin
                    expect_filter_reg <= 1'b1;
                    first_row_reg     <= 1'b0;
                    col_reg           <= '0;
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (pixels_in.image_end)
            begin
                expect_filter_reg <= 1'b1;
                first_row_reg     <= 1'b1;
                discard_reg       <= 1'b0;
                col_reg           <= '0;
            end
        end
    end

    // Hold the stage-one request until it moves to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_err_reg        <= is_filter;
            s1_byte_reg       <= pixels_in.stream_byte;
            s1_filter_reg     <= filter_reg;
            s1_row_start_reg  <= (col_reg == '0);
            s1_above_zero_reg <= first_row_reg;
            s1_col_reg        <= col_reg;
            s1_last_reg       <= last_col;
        end
    end

    // Line store: read at acceptance, write as stage one retires
    logic [7:0] above_raw;
    logic       store_wr;
    logic [7:0] result;

    assign store_wr = s1_go && !s1_err_reg;

    punf_line_store #(
        .DEPTH (MAX_ROW_BYTES),
        .AW    (CW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (in_fire && is_data),
        .rd_addr (col_reg),
        .wr_en   (store_wr),
        .wr_addr (s1_col_reg),
        .wr_data (result),
        .rd_data (above_raw)
    );

    // Left and corner histories, newest first
    logic [7:0] left_hist_reg   [MAX_PIXEL_BYTES];
    logic [7:0] corner_hist_reg [MAX_PIXEL_BYTES];
    logic [7:0] left_eff        [MAX_PIXEL_BYTES];
    logic [7:0] corner_eff      [MAX_PIXEL_BYTES];

    always_comb
    begin
        for (int i = 0; i < MAX_PIXEL_BYTES; i++)
        begin
            left_eff[i]   = s1_row_start_reg ? 8'd0 : left_hist_reg[i];
            corner_eff[i] = s1_row_start_reg ? 8'd0 : corner_hist_reg[i];
        end
    end

    // Reconstruct the data byte
    logic [7:0] left;
    logic [7:0] corner;
    logic [7:0] above;
    logic [8:0] avg_sum;
    logic [7:0] pred;

    assign left    = left_eff[dist_idx];
    assign corner  = corner_eff[dist_idx];
    assign above   = s1_above_zero_reg ? 8'd0 : above_raw;
    assign avg_sum = {1'b0, left} + {1'b0, above};

    always_comb
    begin
        case (s1_filter_reg)
            FILT_SUB:   pred = left;
            FILT_UP:    pred = above;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth_pick(left, above, corner);
            default:    pred = 8'd0;
        endcase
    end

    assign result = s1_byte_reg + pred;

    // Shift the new byte and its above byte into the histories
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i]   <= 8'd0;
                corner_hist_reg[i] <= 8'd0;
            end
        end
        else if (store_wr)
        begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                if (i == 0)
                begin
                    left_hist_reg[i]   <= result;
                    corner_hist_reg[i] <= above;
                end
                else
                begin
                    left_hist_reg[i]   <= left_eff[(i > 0) ? i - 1 : 0];
                    corner_hist_reg[i] <= corner_eff[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pixels_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            out_pixel_reg   <= s1_err_reg ? 8'd0 : result;
            out_row_end_reg <= s1_err_reg ? 1'b0 : s1_last_reg;
            out_error_reg   <= s1_err_reg;
        end
    end

    assign pixels_out.valid      = out_valid_reg;
    assign pixels_out.pixel_byte = out_pixel_reg;
    assign pixels_out.row_end    = out_row_end_reg;
    assign pixels_out.error      = out_error_reg;

endmodule

### test/png_scanline_unfilter_test.sv
// Self-checking testbench for png_scanline_unfilter: feeds filtered PNG rows and
// compares every reconstructed byte with a built-in unfilter predictor.
// Depends on punf_pkg, the punf_*_if interfaces and the block itself.
`timescale 1ns / 1ps

module png_scanline_unfilter_test;
    import punf_pkg::*;

    localparam int MAX_ROW = MAX_ROW_BYTES_DEF;
    localparam int MAX_PB  = MAX_PIXEL_BYTES_DEF;

    // Indexes past the register map; writes to them must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 4'hF;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end;
        logic       error;
    } pixel_result_t;

    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PERIODIC,
        SINK_BLOCKING
    } sink_mode_t;

    logic clk;
    logic rst_n;

    punf_in_if  pix_in_if ();
    punf_out_if pix_out_if ();
    punf_cfg_if cfg_if ();

    png_scanline_unfilter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels_in  (pix_in_if),
        .pixels_out (pix_out_if),
        .cfg        (cfg_if)
    );

    // Predictor state: line store, pixel history, row position and registers
    logic [7:0]    line_store [MAX_ROW];
    logic [7:0]    left_taps [MAX_PB];
    logic [7:0]    corner_taps [MAX_PB];
    int unsigned   col_pos;
    filter_t       row_filter;
    bit            top_row;
    bit            dropping;
    logic [13:0]   cfg_row_bytes;
    logic [3:0]    cfg_pixel_bytes;

    pixel_result_t pending_pixels [$];
    pixel_result_t expected_px;

    // Stimulus pacing and run statistics
    sink_mode_t sink_mode;
    int         stall_span;
    int         sink_phase;
    int         hold_off;
    int         burst_left;
    bit         steady_source;
    int         mismatches;
    int         stream_items;
    int         bytes_checked;
    int         rows_closed;
    int         errors_seen;
    int         images_sent;
    int         cfg_writes;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic int unsigned row_len();
        if (cfg_row_bytes == 0)
        begin
            return 1;
        end
        if (cfg_row_bytes > MAX_ROW)
        begin
            return MAX_ROW;
        end
        return cfg_row_bytes;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Advance the predictor by one accepted byte; push the result it causes
    task automatic unfilter_predict(input logic [7:0] b, input logic img_end, output bit taken);
        int unsigned   col;
        int unsigned   len;
        int unsigned   distance;
        logic [7:0]    left;
        logic [7:0]    corner;
        logic [7:0]    above;
        logic [7:0]    pred;
        logic [7:0]    result;
        int            p;
        int            pa;
        int            pb;
        int            pc;
        pixel_result_t r;
        taken = !dropping;
        if (dropping)
        begin
            // drop everything until the end of the image
        end
        else if (col_pos == 0)
        begin
            if (b > FILT_LAST_CODE)
            begin
                r = '{pixel_byte: 8'h00, row_end: 1'b0, error: 1'b1};
                pending_pixels.push_back(r);
                dropping = 1'b1;
            end
            else
            begin
                row_filter = filter_t'(b[2:0]);
                foreach (left_taps[i])
                begin
                    left_taps[i]   = 8'h00;
                    corner_taps[i] = 8'h00;
                end
                col_pos = 1;
            end
        end
        else
        begin
            col  = col_pos - 1;
            len  = row_len();
            distance = (cfg_pixel_bytes == 0) ? 1 : (cfg_pixel_bytes > MAX_PB) ? MAX_PB
                                                                               : cfg_pixel_bytes;
            left   = left_taps[distance-1];
            corner = corner_taps[distance-1];
            if (col >= MAX_ROW)
            begin
                col = MAX_ROW - 1;
            end
            above = top_row ? 8'h00 : line_store[col];

            case (row_filter)
                FILT_SUB:   pred = left;
                FILT_UP:    pred = above;
                FILT_AVG:   pred = 8'((9'(left) + 9'(above)) >> 1);
                FILT_PAETH:
                begin
                    // Pick the neighbor closest to left + above - corner
                    p  = int'(left) + int'(above) - int'(corner);
                    pa = (p >= int'(left))   ? p - int'(left)   : int'(left) - p;
                    pb = (p >= int'(above))  ? p - int'(above)  : int'(above) - p;
                    pc = (p >= int'(corner)) ? p - int'(corner) : int'(corner) - p;
                    if (pa <= pb && pa <= pc)
                    begin
                        pred = left;
                    end
                    else if (pb <= pc)
                    begin
                        pred = above;
                    end
                    else
                    begin
                        pred = corner;
                    end
                end
                default:    pred = 8'h00;
            endcase
            result = b + pred;

            for (int i = MAX_PB - 1; i > 0; i--)
            begin
                left_taps[i]   = left_taps[i-1];
                corner_taps[i] = corner_taps[i-1];
            end
            left_taps[0]     = result;
            corner_taps[0]   = above;
            line_store[col]  = result;

            r = '{pixel_byte: result, row_end: (col + 1 >= len), error: 1'b0};
            if (r.row_end)
            begin
                col_pos = 0;
                top_row = 1'b0;
            end
            else
            begin
                col_pos = col + 2;
            end
            pending_pixels.push_back(r);
        end

        if (img_end)
        begin
            col_pos  = 0;
            top_row  = 1'b1;
            dropping = 1'b0;
        end
    endtask

    // Send one byte request, predict it on acceptance, then maybe pause
    task automatic send_byte(input logic [7:0] b, input logic img_end);
        bit taken;
        pix_in_if.valid       <= 1'b1;
        pix_in_if.stream_byte <= b;
        pix_in_if.image_end   <= img_end;
        do @(posedge clk); while (!pix_in_if.ready);
        unfilter_predict(b, img_end, taken);
        if (taken)
        begin
            stream_items++;
        end
        if (steady_source || burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            pix_in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Hold off input until every result is back and the pipeline has settled
    task automatic drain_and_settle();
        pix_in_if.valid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Write one register; the caller lowers valid after its last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            REG_ROW_BYTES:       cfg_row_bytes   = val[ROW_BYTES_W-1:0];
            REG_BYTES_PER_PIXEL: cfg_pixel_bytes = val[BPP_W-1:0];
            default:             ;
        endcase
        cfg_writes++;
    endtask

    task automatic apply_config(input int unsigned rb, input logic [3:0] bpp);
        drain_and_settle();
        write_reg(REG_ROW_BYTES, rb[ROW_BYTES_W-1:0]);
        write_reg(REG_BYTES_PER_PIXEL, {10'($urandom_range(0, 1023)), bpp});
        cfg_if.valid <= 1'b0;
    endtask

    // Every filter type on a two-byte row, stacked so Up/Avg/Paeth see real rows
    task automatic test_filter_types();
        filter_t    kinds [5];
        logic [7:0] data [10];
        kinds = '{FILT_NONE, FILT_SUB, FILT_UP, FILT_AVG, FILT_PAETH};
        data  = '{8'hFF, 8'h00, 8'h01, 8'hFF, 8'h80, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h01};
        steady_source = 1'b1;
        sink_mode     <= SINK_OPEN;
        apply_config(2, 4'd1);
        for (int r = 0; r < 5; r++)
        begin
            send_byte(8'(kinds[r]), 1'b0);
            send_byte(data[2*r], 1'b0);
            send_byte(data[2*r+1], r == 4);
        end
        images_sent++;
    endtask

    // Unknown filter types, discarding, and image end on filter and data bytes
    task automatic test_bad_filter();
        steady_source = 1'b0;
        sink_mode     <= SINK_RANDOM;
        send_byte(8'h05, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'(FILT_SUB), 1'b1);
        send_byte(8'(FILT_UP), 1'b0);
        send_byte(8'h5A, 1'b1);
        send_byte(8'hFF, 1'b1);
        images_sent += 4;
    endtask

    // Shrink the row length in the middle of a row: the next byte closes it
    task automatic test_midrow_resize();
        sink_mode <= SINK_PERIODIC;
        apply_config(3, 4'd2);
        send_byte(8'(FILT_NONE), 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'(FILT_AVG), 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b0);
        drain_and_settle();
        write_reg(REG_ROW_BYTES, 14'd1);
        cfg_if.valid <= 1'b0;
        send_byte(8'hC3, 1'b0);
        send_byte(8'(FILT_PAETH), 1'b0);
        send_byte(8'h9C, 1'b1);
        images_sent++;
    endtask

    // Out-of-range register values and writes to unmapped indexes
    task automatic test_register_extremes();
        sink_mode <= SINK_BLOCKING;
        drain_and_settle();
        write_reg(REG_UNMAPPED_HI, '1);
        write_reg(REG_UNMAPPED_LO, 14'(($urandom_range(0, 16383))));
        cfg_if.valid <= 1'b0;
        apply_config(0, 4'd0);
        send_byte(8'(FILT_SUB), 1'b0);
        send_byte(8'hE7, 1'b1);
        apply_config(16383, 4'hF);
        send_byte(8'(FILT_PAETH), 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        images_sent += 2;
    endtask

    // Random images: mostly well-formed rows, some cut short, some with bad filters
    task automatic test_random_images(input int target);
        int unsigned len;
        int unsigned rows;
        int unsigned total;
        int unsigned cut;
        int unsigned bad_row;
        int unsigned rb;
        int          kind;
        logic [3:0]  bpp;
        logic [7:0]  b;
        stream_items = 0;
        while (stream_items < target)
        begin
            // Pick new settings and pacing every few images
            if (images_sent % 3 == 0)
            begin
                case ($urandom_range(0, 19))
                    0:       rb = 0;
                    1:       rb = MAX_ROW;
                    2:       rb = $urandom_range(MAX_ROW + 1, 16383);
                    3, 4:    rb = $urandom_range(25, 200);
                    default: rb = $urandom_range(1, 24);
                endcase
                bpp = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
                apply_config(rb, bpp);
                steady_source = ($urandom_range(0, 4) == 0);
                sink_mode     <= sink_mode_t'($urandom_range(0, 3));
                stall_span    <= $urandom_range(1, 8);
            end

            len     = row_len();
            rows    = (len > 24) ? $urandom_range(1, 3) : $urandom_range(1, 6);
            kind    = $urandom_range(0, 9);
            total   = rows * (len + 1);
            cut     = total - 1;
            bad_row = rows;
            if (len > 200)
            begin
                // Long rows: send only a short head of the first row
                cut = $urandom_range(0, 40);
            end
            else if (kind == 1)
            begin
                cut = $urandom_range(0, total - 1);
            end
            else if (kind == 0)
            begin
                bad_row = $urandom_range(0, rows - 1);
            end

            for (int unsigned pos = 0; pos <= cut; pos++)
            begin
                if (pos % (len + 1) == 0)
                begin
                    if (pos / (len + 1) == bad_row)
                    begin
                        // Broken image: bad filter, some dropped bytes, then the end
                        send_byte(8'($urandom_range(5, 255)), 1'b0);
                        repeat ($urandom_range(0, 6))
                        begin
                            send_byte(8'($urandom_range(0, 255)), 1'b0);
                        end
                        send_byte(8'($urandom_range(0, 255)), 1'b1);
                        break;
                    end
                    b = 8'($urandom_range(0, 4));
                end
                else
                begin
                    case ($urandom_range(0, 7))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                end
                send_byte(b, pos == cut);
            end
            images_sent++;
        end
    endtask

    // Drive the output ready according to the current stall pattern
    always @(posedge clk)
    begin
        case (sink_mode)
            SINK_OPEN:
            begin
                pix_out_if.ready <= 1'b1;
            end
            SINK_RANDOM:
            begin
                pix_out_if.ready <= ($urandom_range(0, 3) != 0);
            end
            SINK_PERIODIC:
            begin
                pix_out_if.ready <= (sink_phase >= stall_span);
                sink_phase       <= (sink_phase + 1) % 11;
            end
            default:
            begin
                if (hold_off > 0)
                begin
                    pix_out_if.ready <= 1'b0;
                    hold_off         <= hold_off - 1;
                end
                else
                begin
                    pix_out_if.ready <= 1'b1;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        hold_off <= $urandom_range(1, 12);
                    end
                end
            end
        endcase
    end

    // Check every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pix_out_if.valid && pix_out_if.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("result with nothing pending", pix_out_if.pixel_byte, 0);
            end
            else
            begin
                expected_px = pending_pixels.pop_front();
                if (pix_out_if.pixel_byte !== expected_px.pixel_byte)
                begin
                    report_mismatch("pixel_byte", pix_out_if.pixel_byte,
                                    expected_px.pixel_byte);
                end
                if (pix_out_if.row_end !== expected_px.row_end)
                begin
                    report_mismatch("row_end", pix_out_if.row_end, expected_px.row_end);
                end
                if (pix_out_if.error !== expected_px.error)
                begin
                    report_mismatch("error", pix_out_if.error, expected_px.error);
                end
                bytes_checked++;
                rows_closed += expected_px.row_end;
                errors_seen += expected_px.error;
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        pix_in_if.valid       = 1'b0;
        pix_in_if.stream_byte = 8'h00;
        pix_in_if.image_end   = 1'b0;
        pix_out_if.ready      = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = REG_ROW_BYTES;
        cfg_if.data           = '0;
        sink_mode             = SINK_OPEN;
        stall_span            = 3;
        sink_phase            = 0;
        hold_off              = 0;
        burst_left            = 0;
        steady_source         = 1'b1;
        mismatches            = 0;
        stream_items          = 0;
        bytes_checked         = 0;
        rows_closed           = 0;
        errors_seen           = 0;
        images_sent           = 0;
        cfg_writes            = 0;
        foreach (line_store[i])
        begin
            line_store[i] = 8'h00;
        end
        foreach (left_taps[i])
        begin
            left_taps[i]   = 8'h00;
            corner_taps[i] = 8'h00;
        end
        col_pos         = 0;
        row_filter      = FILT_NONE;
        top_row         = 1'b1;
        dropping        = 1'b0;
        cfg_row_bytes   = 14'd1;
        cfg_pixel_bytes = 4'd1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_filter_types();
        test_bad_filter();
        test_midrow_resize();
        test_register_extremes();
        test_random_images(1900);

        drain_and_settle();
        repeat (8) @(posedge clk);
        $display("Checked %0d reconstructed bytes over %0d scanlines and %0d filter errors.",
                 bytes_checked, rows_closed, errors_seen);
        $display("Stream covered %0d images with %0d register writes.",
                 images_sent, cfg_writes);
        if (mismatches == 0 && pending_pixels.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #1_000_000;
        $display("Timeout with %0d results still pending", pending_pixels.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
sv/punf_pkg.sv
sv/punf_intf.sv
sv/punf_line_store.sv
sv/png_scanline_unfilter.sv
test/png_scanline_unfilter_test.sv
